// ----- rtl/core/dbsf_pkg.sv -----
// ----------------------------------------------------------------------------
// dbsf_pkg: shared types and constants of the diamond band sepia filter
// Widths, register map, quadrant codes, pipeline enables and tone constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dbsf_pkg;

  // Field and datapath widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SIDE_W     = 14;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned PROD_W     = SIDE_W + CNT_W;
  localparam int unsigned AREA_W     = 2 * SIDE_W;
  localparam int unsigned CMP_W      = AREA_W + 4;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned COEF_W     = 10;
  localparam int unsigned SUM_W      = 19;
  localparam int unsigned RECIP_W    = 18;
  localparam int unsigned DIV_SHIFT  = 27;

  // Configuration port
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned REG_IDX_BIT = 2;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [PIX_W-1:0]              pix_t;
  typedef logic [NUM_CH-1:0][PIX_W-1:0]  rgb_t;
  typedef logic [SIDE_W-1:0]             side_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [PROD_W-1:0]             prod_t;
  typedef logic [AREA_W-1:0]             area_t;
  typedef logic signed [CMP_W-1:0]       cmp_t;
  typedef logic [SUM_W-1:0]              sum_t;
  typedef logic [2*RECIP_W-1:0]          recip_prod_t;

  // Channel order inside rgb_t and the coefficient rows
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  localparam side_t MAX_SIDE   = 14'd8192;
  localparam side_t WIDTH_RST  = 14'd640;
  localparam side_t HEIGHT_RST = 14'd480;

  // Sepia matrix in thousandths: row = output channel, column = input channel
  localparam logic [COEF_W-1:0] TONE_COEF [NUM_CH][NUM_CH] = '{
    '{10'd393, 10'd769, 10'd189},
    '{10'd349, 10'd686, 10'd168},
    '{10'd272, 10'd543, 10'd131}
  };

  // Divide by 1000: multiply by ceil(2^27 / 1000), exact below the saturation limit
  localparam logic [RECIP_W-1:0] RECIP     = 18'd134218;
  localparam sum_t               SAT_LIMIT = 19'd256000;
  localparam pix_t               PIX_MAX   = 8'd255;

  typedef enum logic [2:0] {
    QUAD_NONE,
    QUAD_LL,
    QUAD_LR,
    QUAD_UL,
    QUAD_UR
  } quad_e;

  typedef struct packed {
    side_t width;
    side_t height;
  } frame_size_t;

  // Load enables of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // Clamp a programmed side to the range 1 .. MAX_SIDE
  function automatic side_t eff_side(side_t v);
    side_t r;
    if (v == '0) begin
      r = side_t'(1);
    end else if (v > MAX_SIDE) begin
      r = MAX_SIDE;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dbsf_pix_if.sv -----
// ----------------------------------------------------------------------------
// dbsf_pix_if: pixel input channel
// Valid/ready handshake carrying one RGB pixel per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbsf_pix_if;
  logic                valid;
  logic                ready;
  dbsf_pkg::pix_t      pixel_red;
  dbsf_pkg::pix_t      pixel_green;
  dbsf_pkg::pix_t      pixel_blue;

  modport source (
    output valid, pixel_red, pixel_green, pixel_blue,
    input  ready
  );

  modport sink (
    input  valid, pixel_red, pixel_green, pixel_blue,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/dbsf_res_if.sv -----
// ----------------------------------------------------------------------------
// dbsf_res_if: result channel
// Valid/ready handshake carrying the filtered pixel and its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbsf_res_if;
  logic                valid;
  logic                ready;
  dbsf_pkg::pix_t      out_red;
  dbsf_pkg::pix_t      out_green;
  dbsf_pkg::pix_t      out_blue;
  logic                toned;
  logic                end_of_frame;

  modport source (
    output valid, out_red, out_green, out_blue, toned, end_of_frame,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, toned, end_of_frame,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/dbsf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dbsf_cfg_regs: frame size registers
// APB-style write/read of image width and height; presents clamped sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module dbsf_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dbsf_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [dbsf_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [dbsf_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output dbsf_pkg::frame_size_t                size_o
);

  dbsf_pkg::side_t    width_q;
  dbsf_pkg::side_t    height_q;
  dbsf_pkg::side_t    rd_val;
  dbsf_pkg::reg_idx_e reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = dbsf_pkg::reg_idx_e'(paddr[dbsf_pkg::REG_IDX_BIT]);

  // Write the addressed register in the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dbsf_pkg::WIDTH_RST;
      height_q <= dbsf_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        dbsf_pkg::REG_WIDTH:  width_q  <= pwdata[dbsf_pkg::SIDE_W-1:0];
        dbsf_pkg::REG_HEIGHT: height_q <= pwdata[dbsf_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the programmed value
  always_comb begin
    unique case (reg_idx)
      dbsf_pkg::REG_WIDTH:  rd_val = width_q;
      dbsf_pkg::REG_HEIGHT: rd_val = height_q;
      default:              rd_val = '0;
    endcase
  end

  assign prdata = {{(dbsf_pkg::CFG_DATA_W - dbsf_pkg::SIDE_W){1'b0}}, rd_val};

  // Clamp to the usable range
  assign size_o.width  = dbsf_pkg::eff_side(width_q);
  assign size_o.height = dbsf_pkg::eff_side(height_q);

endmodule

`default_nettype wire

// ----- rtl/core/dbsf_raster_cnt.sv -----
// ----------------------------------------------------------------------------
// dbsf_raster_cnt: raster position counters
// Tracks column and row of the next pixel, wrapping at row and frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module dbsf_raster_cnt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   acc_i,
  input  dbsf_pkg::frame_size_t  size_i,
  output dbsf_pkg::cnt_t         col_o,
  output dbsf_pkg::cnt_t         row_o,
  output logic                   eof_o
);

  dbsf_pkg::cnt_t col_q, col_d;
  dbsf_pkg::cnt_t row_q, row_d;
  logic           eol;

  // End of row / end of frame for the current position
  assign eol   = (dbsf_pkg::side_t'(col_q) + dbsf_pkg::side_t'(1)) >= size_i.width;
  assign eof_o = eol &&
                 ((dbsf_pkg::side_t'(row_q) + dbsf_pkg::side_t'(1)) >= size_i.height);

  // Advance on every accepted word
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc_i) begin
      if (eol) begin
        col_d = '0;
        row_d = eof_o ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o = col_q;
  assign row_o = row_q;

`ifndef SYNTH
  // Frame end returns to the origin
  a_eof_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && eof_o) |=> (col_q == '0 && row_q == '0))
    else $error("raster counters not at origin after frame end");

  // Inside a row the column steps by one and the row holds
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && !eol) |=> (col_q == $past(col_q) + 1'b1 && row_q == $past(row_q)))
    else $error("column did not step by one inside a row");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/dbsf_band_test.sv -----
// ----------------------------------------------------------------------------
// dbsf_band_test: rhombus band membership
// Quadrant pick, cross products, then strict compare against band limits.
// ----------------------------------------------------------------------------
`default_nettype none

module dbsf_band_test (
  input  logic                   clk_i,
  input  dbsf_pkg::stage_en_t    en_i,
  input  dbsf_pkg::frame_size_t  size_i,
  input  dbsf_pkg::cnt_t         col_i,
  input  dbsf_pkg::cnt_t         row_i,
  output logic                   hit_o
);

  // Stage 1: position and frame size of the word
  dbsf_pkg::side_t  w_q, h_q;
  dbsf_pkg::cnt_t   x_q, y_q;
  dbsf_pkg::cnt_t   hw, hh;
  dbsf_pkg::quad_e  quad_d;

  // Stage 2: products
  dbsf_pkg::prod_t  wy_q, hx_q;
  dbsf_pkg::area_t  wh_q;
  dbsf_pkg::quad_e  quad_q;

  // Stage 3: band value and limits
  dbsf_pkg::cmp_t   wy_s, hx_s, wh1, wh2, wh3, wh6, wh7;
  dbsf_pkg::cmp_t   s_d, lo_d, hi_d;
  dbsf_pkg::cmp_t   s_q, lo_q, hi_q;
  logic             inq_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      w_q <= size_i.width;
      h_q <= size_i.height;
      x_q <= col_i;
      y_q <= row_i;
    end
  end

  // Pick the quadrant; the halving lines belong to none
  assign hw = w_q[dbsf_pkg::SIDE_W-1:1];
  assign hh = h_q[dbsf_pkg::SIDE_W-1:1];

  always_comb begin
    if (x_q < hw && y_q < hh) begin
      quad_d = dbsf_pkg::QUAD_LL;
    end else if (x_q > hw && y_q < hh) begin
      quad_d = dbsf_pkg::QUAD_LR;
    end else if (x_q < hw && y_q > hh) begin
      quad_d = dbsf_pkg::QUAD_UL;
    end else if (x_q > hw && y_q > hh) begin
      quad_d = dbsf_pkg::QUAD_UR;
    end else begin
      quad_d = dbsf_pkg::QUAD_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      wy_q   <= dbsf_pkg::prod_t'(w_q) * dbsf_pkg::prod_t'(y_q);
      hx_q   <= dbsf_pkg::prod_t'(h_q) * dbsf_pkg::prod_t'(x_q);
      wh_q   <= dbsf_pkg::area_t'(w_q) * dbsf_pkg::area_t'(h_q);
      quad_q <= quad_d;
    end
  end

  // Form the scaled band value and the two limits of the quadrant
  assign wy_s = dbsf_pkg::cmp_t'(wy_q);
  assign hx_s = dbsf_pkg::cmp_t'(hx_q);
  assign wh1  = dbsf_pkg::cmp_t'(wh_q);
  assign wh2  = wh1 <<< 1;
  assign wh3  = wh1 + wh2;
  assign wh6  = wh3 <<< 1;
  assign wh7  = (wh1 <<< 3) - wh1;

  always_comb begin
    s_d  = '0;
    lo_d = '0;
    hi_d = '0;
    case (quad_q)
      dbsf_pkg::QUAD_LL: begin
        s_d  = (wy_s + hx_s) <<< 2;
        lo_d = wh1;
        hi_d = wh2;
      end
      dbsf_pkg::QUAD_LR: begin
        s_d  = (hx_s - wy_s) <<< 2;
        lo_d = wh2;
        hi_d = wh3;
      end
      dbsf_pkg::QUAD_UL: begin
        s_d  = (wy_s - hx_s) <<< 2;
        lo_d = wh2;
        hi_d = wh3;
      end
      dbsf_pkg::QUAD_UR: begin
        s_d  = (wy_s + hx_s) <<< 2;
        lo_d = wh6;
        hi_d = wh7;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      s_q   <= s_d;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
      inq_q <= (quad_q != dbsf_pkg::QUAD_NONE);
    end
  end

  // Strictly between the two diagonals
  assign hit_o = inq_q && (s_q > lo_q) && (s_q < hi_q);

endmodule

`default_nettype wire

// ----- rtl/core/dbsf_tone.sv -----
// ----------------------------------------------------------------------------
// dbsf_tone: sepia colour matrix
// Matrix sums, divide by 1000 via reciprocal, saturate, then pick toned/raw.
// ----------------------------------------------------------------------------
`default_nettype none

module dbsf_tone (
  input  logic                 clk_i,
  input  dbsf_pkg::stage_en_t  en_i,
  input  dbsf_pkg::rgb_t       pix_i,
  input  logic                 hit_i,
  output dbsf_pkg::rgb_t       pix_o
);

  dbsf_pkg::rgb_t         pix1_q, pix2_q, pix3_q;
  dbsf_pkg::sum_t         sum_d [dbsf_pkg::NUM_CH];
  dbsf_pkg::sum_t         sum_q [dbsf_pkg::NUM_CH];
  dbsf_pkg::recip_prod_t  prod  [dbsf_pkg::NUM_CH];
  dbsf_pkg::rgb_t         quo_d, quo_q;

  // Stage 1: hold the raw pixel
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      pix1_q <= pix_i;
    end
  end

  for (genvar c = 0; c < dbsf_pkg::NUM_CH; c++) begin : g_chan
    // Weighted sum in thousandths
    assign sum_d[c] =
      dbsf_pkg::sum_t'(dbsf_pkg::TONE_COEF[c][dbsf_pkg::CH_RED])
        * dbsf_pkg::sum_t'(pix1_q[dbsf_pkg::CH_RED]) +
      dbsf_pkg::sum_t'(dbsf_pkg::TONE_COEF[c][dbsf_pkg::CH_GREEN])
        * dbsf_pkg::sum_t'(pix1_q[dbsf_pkg::CH_GREEN]) +
      dbsf_pkg::sum_t'(dbsf_pkg::TONE_COEF[c][dbsf_pkg::CH_BLUE])
        * dbsf_pkg::sum_t'(pix1_q[dbsf_pkg::CH_BLUE]);

    // Truncating divide by 1000, clamp at full scale
    assign prod[c] = dbsf_pkg::recip_prod_t'(sum_q[c][dbsf_pkg::RECIP_W-1:0])
                     * dbsf_pkg::recip_prod_t'(dbsf_pkg::RECIP);
    assign quo_d[c] = (sum_q[c] >= dbsf_pkg::SAT_LIMIT) ? dbsf_pkg::PIX_MAX
                                                       : prod[c][dbsf_pkg::DIV_SHIFT +:
                                                                 dbsf_pkg::PIX_W];

    always_ff @(posedge clk_i) begin
      if (en_i.s2) begin
        sum_q[c] <= sum_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      pix2_q <= pix1_q;
    end
    if (en_i.s3) begin
      pix3_q <= pix2_q;
      quo_q  <= quo_d;
    end
  end

  // Toned inside the band, unchanged elsewhere
  assign pix_o = hit_i ? quo_q : pix3_q;

endmodule

`default_nettype wire

// ----- rtl/core/diamond_band_sepia_filter.sv -----
// Path: an accepted word passes the input register, product stage, band/divide
//   stage and result register in that order before it shows on res_o.
// Throughput: one pixel per cycle; each stage refills as soon as it empties, so
//   input is taken while a result waits, and stops only when all four stages hold.
// Reset: asynchronous, active low; clears stage valids and raster position and
//   loads width 640 and height 480.
// ----------------------------------------------------------------------------
// diamond_band_sepia_filter: sepia toning inside a rhombus band
// Counts raster position, tests band membership and tones the pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module diamond_band_sepia_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  dbsf_pix_if.sink                             pix_i,
  dbsf_res_if.source                           res_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dbsf_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [dbsf_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [dbsf_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  dbsf_pkg::frame_size_t size;
  dbsf_pkg::stage_en_t   en;
  dbsf_pkg::cnt_t        col, row;
  dbsf_pkg::rgb_t        pix_in, pix_res, out_rgb_q;
  logic                  eof;
  logic                  hit;
  logic                  acc;
  logic                  v1_q, v2_q, v3_q, out_v_q;
  logic                  rdy1, rdy2, rdy3, rdy4;
  logic                  eof1_q, eof2_q, eof3_q;
  logic                  toned_q, eof_out_q;

  // Frame size registers
  dbsf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_o  (size)
  );

  // Stage handshake: a stage loads when it is empty or its word moves on
  assign rdy4 = !out_v_q || res_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign pix_i.ready = rdy1;
  assign acc         = pix_i.valid && rdy1;

  assign en.s1 = acc;
  assign en.s2 = v1_q && rdy2;
  assign en.s3 = v2_q && rdy3;
  assign en.s4 = v3_q && rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1) v1_q    <= pix_i.valid;
      if (rdy2) v2_q    <= v1_q;
      if (rdy3) v3_q    <= v2_q;
      if (rdy4) out_v_q <= v3_q;
    end
  end

  // Raster position of the incoming word
  dbsf_raster_cnt u_raster (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .size_i (size),
    .col_o  (col),
    .row_o  (row),
    .eof_o  (eof)
  );

  dbsf_band_test u_band (
    .clk_i  (clk_i),
    .en_i   (en),
    .size_i (size),
    .col_i  (col),
    .row_i  (row),
    .hit_o  (hit)
  );

  assign pix_in[dbsf_pkg::CH_RED]   = pix_i.pixel_red;
  assign pix_in[dbsf_pkg::CH_GREEN] = pix_i.pixel_green;
  assign pix_in[dbsf_pkg::CH_BLUE]  = pix_i.pixel_blue;

  dbsf_tone u_tone (
    .clk_i (clk_i),
    .en_i  (en),
    .pix_i (pix_in),
    .hit_i (hit),
    .pix_o (pix_res)
  );

  // Carry the frame-end flag alongside the pixel, then register the result
  always_ff @(posedge clk_i) begin
    if (en.s1) eof1_q <= eof;
    if (en.s2) eof2_q <= eof1_q;
    if (en.s3) eof3_q <= eof2_q;
    if (en.s4) begin
      out_rgb_q <= pix_res;
      toned_q   <= hit;
      eof_out_q <= eof3_q;
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.out_red      = out_rgb_q[dbsf_pkg::CH_RED];
  assign res_o.out_green    = out_rgb_q[dbsf_pkg::CH_GREEN];
  assign res_o.out_blue     = out_rgb_q[dbsf_pkg::CH_BLUE];
  assign res_o.toned        = toned_q;
  assign res_o.end_of_frame = eof_out_q;

`ifndef SYNTH
  // Input is refused only when every stage holds a word
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (v1_q && v2_q && v3_q && out_v_q))
    else $error("input refused with a free pipeline stage");

  // A word in the last inner stage with a free result register lands there
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && (!res_o.valid || res_o.ready)) |=> res_o.valid)
    else $error("word lost between band stage and result register");
`endif

endmodule

`default_nettype wire
